/* rtl/core/sdpt_pkg.sv */
// shared widths, constants, codes and the angle wrap for the pan/tilt tracker
package sdpt_pkg;

   // angle fixed point: 1/2^F degree
   localparam int ANGLE_FRAC_BITS = 7;

   localparam int ANGLE_W = 16;
   localparam int PITCH_OUT_W = 15;
   localparam int RATE_W = 24;
   localparam int ACC_W = 25;
   localparam int DIFF_W = 18;
   localparam int SUM_W = 26;
   localparam int KERR_W = 33;
   localparam int CLAMP_W = 34;
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 17;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int TS_SHIFT = 16;
   localparam int DELTA_W = 25;
   localparam int MOD_W = 25;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int HALF_TURN_I = 180 * (2 ** ANGLE_FRAC_BITS);
   localparam int FULL_TURN_I = 2 * HALF_TURN_I;

   // yaw reduction: offset by whole turns to stay positive, then quotient by reciprocal
   // full turn = 45 << MOD_SHIFT, so drop the low bits and divide by 45
   localparam int MOD_TURNS = 256;
   localparam int MOD_OFFSET_I = FULL_TURN_I * MOD_TURNS;
   localparam int MOD_SHIFT = ANGLE_FRAC_BITS + 3;
   localparam int MOD_ODD = 45;
   localparam int MOD_RECIP_SHIFT = 20;
   localparam int MOD_RECIP_I = ((2 ** MOD_RECIP_SHIFT) + MOD_ODD - 1) / MOD_ODD;
   localparam int MOD_QUO_W = 9;

   localparam logic signed [DIFF_W-1:0] HALF_D = DIFF_W'(HALF_TURN_I);
   localparam logic signed [DIFF_W-1:0] FULL_D = DIFF_W'(FULL_TURN_I);
   localparam logic signed [SUM_W-1:0] MOD_OFFSET_S = SUM_W'(MOD_OFFSET_I);
   localparam logic signed [MUL_B_W-1:0] MOD_RECIP_B = MUL_B_W'(MOD_RECIP_I);
   localparam logic signed [MUL_B_W-1:0] FULL_B = MUL_B_W'(FULL_TURN_I);
   localparam logic [MOD_W-1:0] FULL_M = MOD_W'(FULL_TURN_I);

   // rate saturation limits
   localparam logic signed [SUM_W-1:0] RATE_MAX_S = SUM_W'((2 ** (RATE_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] RATE_MIN_S = -SUM_W'(2 ** (RATE_W - 1));

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STIFF_IDLE   = 3'd0,
      CSR_DAMP_IDLE    = 3'd1,
      CSR_STIFF_ATTACK = 3'd2,
      CSR_DAMP_ATTACK  = 3'd3,
      CSR_MAX_ACCEL    = 3'd4,
      CSR_TIME_STEP    = 3'd5,
      CSR_SNAP_TOL     = 3'd6,
      CSR_PITCH_LIMIT  = 3'd7
   } csr_index_type;

   // request into the shared multiplier
   typedef struct packed {
      logic                       en;
      logic signed [MUL_A_W-1:0]  a;
      logic signed [MUL_B_W-1:0]  b;
   } mul_req_type;

   // reduce a difference into [-half turn, half turn), one correction is enough
   function automatic logic signed [ANGLE_W-1:0] wrap_half(input logic signed [DIFF_W-1:0] v);
      logic signed [DIFF_W-1:0] r;
      r = v;
      if (v >= HALF_D) begin
         r = v - FULL_D;
      end else if (v < -HALF_D) begin
         r = v + FULL_D;
      end
      return r[ANGLE_W-1:0];
   endfunction

endpackage

/* rtl/core/sdpt_mul.sv */
// shared signed multiplier with registered product
module sdpt_mul
   import sdpt_pkg::*;
(
   input  logic                      clock,
   input  mul_req_type               mul_req,
   output logic signed [PROD_W-1:0]  prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // full-width signed product
   assign prod_in = PROD_W'($signed(mul_req.a)) * PROD_W'($signed(mul_req.b));

   // product register, loaded on request
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

/* rtl/core/spring_damper_pan_tilt_tracker_core.sv */
// top level of the spring-damper pan/tilt tracker with one shared multiplier
//
//   channel | direction | handshake           | word
//   req_    | in        | req_valid/req_stall | target yaw, target pitch, attacking
//   rsp_    | out       | rsp_valid/rsp_stall | view yaw/pitch, snapped, both rates
//   csr_    | in        | csr_wr_en           | index, write data (no read-back)
//
// the sequencer feeds one 25x17 multiplier four times per axis plus twice more for the
// reciprocal reduction of the updated yaw; a snapped yaw skips its own multiplies and
// the reduction, and a new item is taken only once the sequencer is back in idle.
// reset is synchronous and clears the axis state and restores the register defaults.
// a finished word waits in the output register; the next word is taken meanwhile, and
// the sequencer holds at its last step only if the output register is still full.
module spring_damper_pan_tilt_tracker_core
   import sdpt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ANGLE_W-1:0]     req_target_yaw,
   input  logic signed [ANGLE_W-1:0]     req_target_pitch,
   input  logic                          req_attacking,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ANGLE_W-1:0]     rsp_view_yaw,
   output logic signed [PITCH_OUT_W-1:0] rsp_view_pitch,
   output logic                          rsp_yaw_snapped,
   output logic signed [RATE_W-1:0]      rsp_yaw_rate_out,
   output logic signed [RATE_W-1:0]      rsp_pitch_rate_out,
   // register write port
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_YERR = 14'b00000000000010,
      ST_PERR = 14'b00000000000100,
      ST_MKE  = 14'b00000000001000,
      ST_MDR  = 14'b00000000010000,
      ST_CLP  = 14'b00000000100000,
      ST_MTA  = 14'b00000001000000,
      ST_RATE = 14'b00000010000000,
      ST_MTR  = 14'b00000100000000,
      ST_ANG  = 14'b00001000000000,
      ST_MQ   = 14'b00010000000000,
      ST_MR   = 14'b00100000000000,
      ST_FIX  = 14'b01000000000000,
      ST_OUT  = 14'b10000000000000
   } state_type;

   // configuration registers
   logic [9:0]  stiff_idle_ff, stiff_attack_ff;
   logic [7:0]  damp_idle_ff, damp_attack_ff;
   logic [15:0] max_accel_ff, time_step_ff;
   logic [11:0] snap_tol_ff;
   logic [13:0] pitch_limit_ff;

   // sequencer and working registers
   state_type                  state_ff, state_in;
   logic                       axis_ff, axis_in;       // 0 yaw, 1 pitch
   logic signed [ANGLE_W-1:0]  ty_ff, ty_in, tp_ff, tp_in;
   logic                       att_ff, att_in;
   logic                       snap_ff, snap_in;
   logic signed [ANGLE_W-1:0]  err_ff, err_in;
   logic signed [KERR_W-1:0]   kerr_ff, kerr_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [MOD_W-1:0]           mod_ff, mod_in;

   // axis state
   logic signed [ANGLE_W-1:0]  yaw_angle_ff, yaw_angle_in, pitch_angle_ff, pitch_angle_in;
   logic signed [RATE_W-1:0]   yaw_rate_ff, yaw_rate_in, pitch_rate_ff, pitch_rate_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0]     out_yaw_ff, out_yaw_in;
   logic signed [PITCH_OUT_W-1:0] out_pitch_ff, out_pitch_in;
   logic                          out_snap_ff, out_snap_in;
   logic signed [RATE_W-1:0]      out_yrate_ff, out_yrate_in, out_prate_ff, out_prate_in;

   // multiplier
   mul_req_type               mul_req;
   logic signed [PROD_W-1:0]  prod_ff;

   // datapath terms
   logic [9:0]                 k_sel;
   logic [10:0]                k_eff;
   logic [7:0]                 d_sel;
   logic signed [RATE_W-1:0]   cur_rate;
   logic signed [ANGLE_W-1:0]  cur_angle;
   logic signed [DELTA_W-1:0]  delta;
   logic signed [SUM_W-1:0]    step_sum;
   logic signed [CLAMP_W-1:0]  acc_full, acc_lim;
   logic signed [SUM_W-1:0]    plim;
   logic signed [ANGLE_W:0]    err_x, tol_x;
   logic                       snap_hit;
   logic                       req_take, out_free;
   logic [MOD_W-1:0]           rem_mod;
   logic signed [DIFF_W-1:0]   fix_val;

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // gain selection, pitch stiffness doubled
   assign k_sel = att_ff ? stiff_attack_ff : stiff_idle_ff;
   assign d_sel = att_ff ? damp_attack_ff : damp_idle_ff;
   assign k_eff = axis_ff ? {k_sel, 1'b0} : {1'b0, k_sel};
   assign cur_rate = axis_ff ? pitch_rate_ff : yaw_rate_ff;
   assign cur_angle = axis_ff ? pitch_angle_ff : yaw_angle_ff;

   // time step product floored by the shift
   assign delta = prod_ff[TS_SHIFT+DELTA_W-1:TS_SHIFT];

   // snap window test on the wrapped yaw error
   assign err_x = (ANGLE_W + 1)'(wrap_half(DIFF_W'(ty_ff) - DIFF_W'(yaw_angle_ff)));
   assign tol_x = $signed((ANGLE_W + 1)'(snap_tol_ff));
   assign snap_hit = (err_x < tol_x) && (err_x > -tol_x);

   // acceleration before and at the clamp
   assign acc_full = CLAMP_W'(kerr_ff) - CLAMP_W'($signed(prod_ff[KERR_W-1:0]));
   assign acc_lim = $signed(CLAMP_W'(max_accel_ff)) <<< ANGLE_FRAC_BITS;
   assign plim = $signed(SUM_W'(pitch_limit_ff));

   // shared adder for rate and angle updates
   always_comb begin
      if (state_ff == ST_RATE) begin
         step_sum = SUM_W'(cur_rate) + SUM_W'(delta);
      end else begin
         step_sum = SUM_W'(cur_angle) + SUM_W'(delta);
      end
   end

   // remainder after taking off whole turns
   assign rem_mod = mod_ff - prod_ff[MOD_W-1:0];
   assign fix_val = $signed(DIFF_W'(rem_mod[ANGLE_W:0]));

   // sequencer and datapath next state
   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      ty_in = ty_ff;
      tp_in = tp_ff;
      att_in = att_ff;
      snap_in = snap_ff;
      err_in = err_ff;
      kerr_in = kerr_ff;
      acc_in = acc_ff;
      mod_in = mod_ff;
      yaw_angle_in = yaw_angle_ff;
      pitch_angle_in = pitch_angle_ff;
      yaw_rate_in = yaw_rate_ff;
      pitch_rate_in = pitch_rate_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_yaw_in = out_yaw_ff;
      out_pitch_in = out_pitch_ff;
      out_snap_in = out_snap_ff;
      out_yrate_in = out_yrate_ff;
      out_prate_in = out_prate_ff;
      mul_req.en = 1'b0;
      mul_req.a = '0;
      mul_req.b = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ty_in = req_target_yaw;
               tp_in = req_target_pitch;
               att_in = req_attacking;
               state_in = ST_YERR;
            end
         end
         // yaw error, snap or start the spring update
         ST_YERR: begin
            err_in = err_x[ANGLE_W-1:0];
            snap_in = snap_hit;
            axis_in = 1'b0;
            if (snap_hit) begin
               yaw_rate_in = '0;
               yaw_angle_in = wrap_half(DIFF_W'(ty_ff));
               state_in = ST_PERR;
            end else begin
               state_in = ST_MKE;
            end
         end
         ST_PERR: begin
            err_in = wrap_half(DIFF_W'(tp_ff) - DIFF_W'(pitch_angle_ff));
            axis_in = 1'b1;
            state_in = ST_MKE;
         end
         // stiffness times error
         ST_MKE: begin
            mul_req.en = 1'b1;
            mul_req.a = MUL_A_W'(err_ff);
            mul_req.b = $signed(MUL_B_W'(k_eff));
            state_in = ST_MDR;
         end
         // damping times rate
         ST_MDR: begin
            kerr_in = $signed(prod_ff[KERR_W-1:0]);
            mul_req.en = 1'b1;
            mul_req.a = MUL_A_W'(cur_rate);
            mul_req.b = $signed(MUL_B_W'(d_sel));
            state_in = ST_CLP;
         end
         // clamp acceleration
         ST_CLP: begin
            if (acc_full > acc_lim) begin
               acc_in = ACC_W'(acc_lim);
            end else if (acc_full < -acc_lim) begin
               acc_in = ACC_W'(-acc_lim);
            end else begin
               acc_in = ACC_W'(acc_full);
            end
            state_in = ST_MTA;
         end
         ST_MTA: begin
            mul_req.en = 1'b1;
            mul_req.a = acc_ff;
            mul_req.b = $signed(MUL_B_W'(time_step_ff));
            state_in = ST_RATE;
         end
         // integrate rate with saturation
         ST_RATE: begin
            if (step_sum > RATE_MAX_S) begin
               acc_in = '0;
               if (axis_ff) pitch_rate_in = RATE_W'(RATE_MAX_S);
               else yaw_rate_in = RATE_W'(RATE_MAX_S);
            end else if (step_sum < RATE_MIN_S) begin
               if (axis_ff) pitch_rate_in = RATE_W'(RATE_MIN_S);
               else yaw_rate_in = RATE_W'(RATE_MIN_S);
            end else begin
               if (axis_ff) pitch_rate_in = RATE_W'(step_sum);
               else yaw_rate_in = RATE_W'(step_sum);
            end
            state_in = ST_MTR;
         end
         ST_MTR: begin
            mul_req.en = 1'b1;
            mul_req.a = MUL_A_W'(cur_rate);
            mul_req.b = $signed(MUL_B_W'(time_step_ff));
            state_in = ST_ANG;
         end
         // integrate angle: pitch clamps, yaw goes to the reduction
         ST_ANG: begin
            if (axis_ff) begin
               if (step_sum < -plim) begin
                  pitch_angle_in = ANGLE_W'(-plim);
               end else if (step_sum > plim) begin
                  pitch_angle_in = ANGLE_W'(plim);
               end else begin
                  pitch_angle_in = ANGLE_W'(step_sum);
               end
               state_in = ST_OUT;
            end else begin
               mod_in = MOD_W'(step_sum + MOD_OFFSET_S);
               state_in = ST_MQ;
            end
         end
         // whole turns: high bits times the reciprocal of the odd factor
         ST_MQ: begin
            mul_req.en = 1'b1;
            mul_req.a = MUL_A_W'(mod_ff[MOD_W-1:MOD_SHIFT]);
            mul_req.b = MOD_RECIP_B;
            state_in = ST_MR;
         end
         // whole turns back to angle units
         ST_MR: begin
            mul_req.en = 1'b1;
            mul_req.a = MUL_A_W'(prod_ff[MOD_RECIP_SHIFT+MOD_QUO_W-1:MOD_RECIP_SHIFT]);
            mul_req.b = FULL_B;
            state_in = ST_FIX;
         end
         // move [0, full) into [-half, half)
         ST_FIX: begin
            if (fix_val >= HALF_D) begin
               yaw_angle_in = ANGLE_W'(fix_val - FULL_D);
            end else begin
               yaw_angle_in = ANGLE_W'(fix_val);
            end
            state_in = ST_PERR;
         end
         // load the output register once it is free
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_yaw_in = yaw_angle_ff;
               out_pitch_in = pitch_angle_ff[PITCH_OUT_W-1:0];
               out_snap_in = snap_ff;
               out_yrate_in = yaw_rate_ff;
               out_prate_in = pitch_rate_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   sdpt_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   // control and axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         yaw_angle_ff <= '0;
         pitch_angle_ff <= '0;
         yaw_rate_ff <= '0;
         pitch_rate_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         yaw_angle_ff <= yaw_angle_in;
         pitch_angle_ff <= pitch_angle_in;
         yaw_rate_ff <= yaw_rate_in;
         pitch_rate_ff <= pitch_rate_in;
      end
   end

   // working and output payload registers
   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
      ty_ff <= ty_in;
      tp_ff <= tp_in;
      att_ff <= att_in;
      snap_ff <= snap_in;
      err_ff <= err_in;
      kerr_ff <= kerr_in;
      acc_ff <= acc_in;
      mod_ff <= mod_in;
      out_yaw_ff <= out_yaw_in;
      out_pitch_ff <= out_pitch_in;
      out_snap_ff <= out_snap_in;
      out_yrate_ff <= out_yrate_in;
      out_prate_ff <= out_prate_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_idle_ff <= 10'd200;
         damp_idle_ff <= 8'd25;
         stiff_attack_ff <= 10'd300;
         damp_attack_ff <= 8'd30;
         max_accel_ff <= 16'd3000;
         time_step_ff <= 16'd2185;
         snap_tol_ff <= 12'd128;
         pitch_limit_ff <= 14'd11392;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_STIFF_IDLE:   stiff_idle_ff <= csr_wdata[9:0];
            CSR_DAMP_IDLE:    damp_idle_ff <= csr_wdata[7:0];
            CSR_STIFF_ATTACK: stiff_attack_ff <= csr_wdata[9:0];
            CSR_DAMP_ATTACK:  damp_attack_ff <= csr_wdata[7:0];
            CSR_MAX_ACCEL:    max_accel_ff <= csr_wdata;
            CSR_TIME_STEP:    time_step_ff <= csr_wdata;
            CSR_SNAP_TOL:     snap_tol_ff <= csr_wdata[11:0];
            CSR_PITCH_LIMIT:  pitch_limit_ff <= csr_wdata[13:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_view_yaw = out_yaw_ff;
   assign rsp_view_pitch = out_pitch_ff;
   assign rsp_yaw_snapped = out_snap_ff;
   assign rsp_yaw_rate_out = out_yrate_ff;
   assign rsp_pitch_rate_out = out_prate_ff;

   // an accepted word always starts with the yaw error step
   a_accept_to_yerr: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_YERR)
      else $error("accepted word did not start the yaw step");

   // a new response only appears from the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output step");

   // held yaw is always reduced to half a turn either way
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (SUM_W'(yaw_angle_ff) >= -SUM_W'(HALF_D)) &&
                              (SUM_W'(yaw_angle_ff) < SUM_W'(HALF_D)))
      else $error("yaw angle out of range");

   // reciprocal reduction leaves less than one full turn
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIX |-> rem_mod < FULL_M)
      else $error("yaw reduction lost its bound");

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the spring-damper pan/tilt tracker core
module tb_top
   import sdpt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // one request word: targets and the attack flag
   typedef struct {
      logic signed [ANGLE_W-1:0] yaw;
      logic signed [ANGLE_W-1:0] pitch;
      logic                      attacking;
   } target_type;

   // one response word: the updated view
   typedef struct {
      logic signed [ANGLE_W-1:0]     view_yaw;
      logic signed [PITCH_OUT_W-1:0] view_pitch;
      logic                          yaw_snapped;
      logic signed [RATE_W-1:0]      yaw_rate;
      logic signed [RATE_W-1:0]      pitch_rate;
   } view_type;

   localparam longint HALF_TURN = longint'(HALF_TURN_I);
   localparam longint FULL_TURN = longint'(FULL_TURN_I);
   localparam longint RATE_HI = (longint'(1) <<< (RATE_W - 1)) - 1;
   localparam longint RATE_LO = -(longint'(1) <<< (RATE_W - 1));
   localparam int YAW_LO = -23040;
   localparam int YAW_HI = 23039;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [ANGLE_W-1:0]     req_target_yaw = '0;
   logic signed [ANGLE_W-1:0]     req_target_pitch = '0;
   logic                          req_attacking = 1'b0;

   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [ANGLE_W-1:0]     rsp_view_yaw;
   logic signed [PITCH_OUT_W-1:0] rsp_view_pitch;
   logic                          rsp_yaw_snapped;
   logic signed [RATE_W-1:0]      rsp_yaw_rate_out;
   logic signed [RATE_W-1:0]      rsp_pitch_rate_out;

   logic                          csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;

   spring_damper_pan_tilt_tracker_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_target_yaw     (req_target_yaw),
      .req_target_pitch   (req_target_pitch),
      .req_attacking      (req_attacking),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_view_yaw       (rsp_view_yaw),
      .rsp_view_pitch     (rsp_view_pitch),
      .rsp_yaw_snapped    (rsp_yaw_snapped),
      .rsp_yaw_rate_out   (rsp_yaw_rate_out),
      .rsp_pitch_rate_out (rsp_pitch_rate_out),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // tracker shadow: register copies and axis state
   longint csr_val [8];
   longint trk_yaw, trk_pitch, trk_yaw_rate, trk_pitch_rate;

   target_type target_queue[$];
   view_type   view_expect[$];
   target_type cur_target;
   int      failures = 0;
   int      send_gap = 0;
   int      send_calm = 0;
   int      stall_left = 0;
   int      stall_calm = 0;
   int      hold_left = 0;
   int      run_cycles = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int csr_width(input csr_index_type idx);
      case (idx)
         CSR_STIFF_IDLE, CSR_STIFF_ATTACK: return 10;
         CSR_DAMP_IDLE, CSR_DAMP_ATTACK:   return 8;
         CSR_SNAP_TOL:                     return 12;
         CSR_PITCH_LIMIT:                  return 14;
         default:                          return 16;
      endcase
   endfunction

   // reduce an angle into [-half turn, half turn)
   function automatic longint wrap_turn(input longint a);
      longint r;
      r = a % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      if (r >= HALF_TURN) r -= FULL_TURN;
      return r;
   endfunction

   // spring-damper update of one axis, floor shifts by the time step
   function automatic void spring_update(inout longint ang, inout longint rate,
                                         input longint err, input longint k,
                                         input longint d);
      longint lim, acc, ts;
      lim = csr_val[CSR_MAX_ACCEL] <<< ANGLE_FRAC_BITS;
      ts = csr_val[CSR_TIME_STEP];
      acc = k * err - d * rate;
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      rate = rate + ((ts * acc) >>> TS_SHIFT);
      if (rate > RATE_HI) rate = RATE_HI;
      else if (rate < RATE_LO) rate = RATE_LO;
      ang = ang + ((ts * rate) >>> TS_SHIFT);
   endfunction

   // advance the shadow tracker by one tick and return the expected view
   function automatic view_type advance_tracker(input target_type t);
      view_type v;
      longint ty, tp, k, d, err, tol, plim;
      logic   snap;
      ty = longint'($signed(t.yaw));
      tp = longint'($signed(t.pitch));
      k = t.attacking ? csr_val[CSR_STIFF_ATTACK] : csr_val[CSR_STIFF_IDLE];
      d = t.attacking ? csr_val[CSR_DAMP_ATTACK] : csr_val[CSR_DAMP_IDLE];
      tol = csr_val[CSR_SNAP_TOL];
      plim = csr_val[CSR_PITCH_LIMIT];
      // yaw: snap when close, else spring, then wrap
      err = wrap_turn(ty - trk_yaw);
      snap = (err < tol) && (err > -tol);
      if (snap) begin
         trk_yaw_rate = 0;
         trk_yaw = ty;
      end else begin
         spring_update(trk_yaw, trk_yaw_rate, err, k, d);
      end
      trk_yaw = wrap_turn(trk_yaw);
      // pitch: doubled stiffness, no snap, clamp
      err = wrap_turn(tp - trk_pitch);
      spring_update(trk_pitch, trk_pitch_rate, err, 2 * k, d);
      if (trk_pitch < -plim) trk_pitch = -plim;
      else if (trk_pitch > plim) trk_pitch = plim;
      v.view_yaw = ANGLE_W'(trk_yaw);
      v.view_pitch = PITCH_OUT_W'(trk_pitch);
      v.yaw_snapped = snap;
      v.yaw_rate = RATE_W'(trk_yaw_rate);
      v.pitch_rate = RATE_W'(trk_pitch_rate);
      return v;
   endfunction

   // idle length: mostly short, a few long, with stretches of none
   function automatic int idle_length(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 70);
   endfunction

   // request driver: present queued words, record the expectation on accept
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            view_expect.push_back(advance_tracker(cur_target));
            send_gap = idle_length(send_calm);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (target_queue.size() != 0) begin
               cur_target = target_queue.pop_front();
               req_valid <= 1'b1;
               req_target_yaw <= cur_target.yaw;
               req_target_pitch <= cur_target.pitch;
               req_attacking <= cur_target.attacking;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall: random gaps plus two long hold-offs that back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         run_cycles++;
         if (run_cycles == 3000 || run_cycles == 20000) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_length(stall_calm);
         end
      end
   end

   // response monitor: compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      view_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (view_expect.size() == 0) begin
            $error("response word with nothing expected");
            failures++;
         end else begin
            e = view_expect.pop_front();
            if (rsp_view_yaw !== e.view_yaw) begin
               $error("view_yaw: expected %0d, got %0d", e.view_yaw, rsp_view_yaw);
               failures++;
            end
            if (rsp_view_pitch !== e.view_pitch) begin
               $error("view_pitch: expected %0d, got %0d", e.view_pitch, rsp_view_pitch);
               failures++;
            end
            if (rsp_yaw_snapped !== e.yaw_snapped) begin
               $error("yaw_snapped: expected %0d, got %0d", e.yaw_snapped, rsp_yaw_snapped);
               failures++;
            end
            if (rsp_yaw_rate_out !== e.yaw_rate) begin
               $error("yaw_rate_out: expected %0d, got %0d", e.yaw_rate, rsp_yaw_rate_out);
               failures++;
            end
            if (rsp_pitch_rate_out !== e.pitch_rate) begin
               $error("pitch_rate_out: expected %0d, got %0d", e.pitch_rate,
                      rsp_pitch_rate_out);
               failures++;
            end
         end
      end
   end

   task automatic push_target(input int y, input int p, input bit att);
      target_type t;
      t.yaw = ANGLE_W'(y);
      t.pitch = ANGLE_W'(p);
      t.attacking = att;
      target_queue.push_back(t);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      csr_val[idx] = longint'(value) & ((longint'(1) <<< csr_width(idx)) - 1);
   endtask

   task automatic program_settings(input int k_i, input int d_i, input int k_a,
                                   input int d_a, input int accel, input int step,
                                   input int tol, input int plim);
      write_csr(CSR_STIFF_IDLE, k_i);
      write_csr(CSR_DAMP_IDLE, d_i);
      write_csr(CSR_STIFF_ATTACK, k_a);
      write_csr(CSR_DAMP_ATTACK, d_a);
      write_csr(CSR_MAX_ACCEL, accel);
      write_csr(CSR_TIME_STEP, step);
      write_csr(CSR_SNAP_TOL, tol);
      write_csr(CSR_PITCH_LIMIT, plim);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // random settings: half near the usual operating point, half over wider ranges
   task automatic program_random_settings();
      if ($urandom_range(0, 1) == 0) begin
         program_settings($urandom_range(50, 400), $urandom_range(5, 60),
                          $urandom_range(50, 400), $urandom_range(5, 60),
                          $urandom_range(500, 8000), $urandom_range(1000, 4000),
                          $urandom_range(0, 2560), $urandom_range(0, 11520));
      end else begin
         program_settings($urandom_range(0, 1023), $urandom_range(0, 255),
                          $urandom_range(0, 1023), $urandom_range(0, 255),
                          $urandom_range(0, 65535), $urandom_range(1, 65535),
                          $urandom_range(0, 2560), $urandom_range(0, 11520));
      end
   endtask

   // queue n words: held targets with jitter, sweeps across the wrap, random and noise
   task automatic queue_phase(input int n);
      int left, len, kind, y, p, dy, i;
      bit att;
      left = n;
      while (left > 0) begin
         kind = $urandom_range(0, 99);
         len = $urandom_range(5, 60);
         if (len > left) len = left;
         y = $urandom_range(0, YAW_HI - YAW_LO) + YAW_LO;
         p = $urandom_range(0, YAW_HI - YAW_LO) + YAW_LO;
         att = $urandom_range(0, 1);
         dy = $urandom_range(20, 400);
         if ($urandom_range(0, 1) == 1) dy = -dy;
         for (i = 0; i < len; i++) begin
            if (kind < 55) begin
               // held target with small jitter, attack flag mostly steady
               if ($urandom_range(0, 3) == 0) y = y + $urandom_range(0, 6) - 3;
               if ($urandom_range(0, 15) == 0) att = ~att;
               push_target(y, p, att);
            end else if (kind < 75) begin
               // steady sweep that crosses the half-turn boundary
               y = y + dy;
               if (y > YAW_HI) y = y - 2 * HALF_TURN_I;
               if (y < YAW_LO) y = y + 2 * HALF_TURN_I;
               push_target(y, p, att);
            end else if (kind < 90) begin
               push_target($urandom_range(0, YAW_HI - YAW_LO) + YAW_LO,
                           $urandom_range(0, YAW_HI - YAW_LO) + YAW_LO,
                           $urandom_range(0, 1));
            end else begin
               // raw 16-bit words, out-of-range angles included
               push_target($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 1));
            end
         end
         left -= len;
      end
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (target_queue.size() != 0 || req_valid || view_expect.size() != 0);
   endtask

   // run limit
   initial begin
      #30_000_000;
      $display("FAIL spring_damper_pan_tilt_tracker_core");
      $finish;
   end

   // stimulus sequence
   initial begin
      int ph;
      csr_val[CSR_STIFF_IDLE] = 200;
      csr_val[CSR_DAMP_IDLE] = 25;
      csr_val[CSR_STIFF_ATTACK] = 300;
      csr_val[CSR_DAMP_ATTACK] = 30;
      csr_val[CSR_MAX_ACCEL] = 3000;
      csr_val[CSR_TIME_STEP] = 2185;
      csr_val[CSR_SNAP_TOL] = 128;
      csr_val[CSR_PITCH_LIMIT] = 11392;
      trk_yaw = 0;
      trk_pitch = 0;
      trk_yaw_rate = 0;
      trk_pitch_rate = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: snap inside and just at the tolerance, field extremes, wrap crossing
      push_target(0, 0, 1'b0);
      push_target(127, 0, 1'b0);
      push_target(255, 0, 1'b0);
      push_target(YAW_HI, YAW_HI, 1'b1);
      push_target(YAW_LO, YAW_LO, 1'b0);
      push_target(32767, 32767, 1'b1);
      push_target(-32768, -32768, 1'b0);
      push_target(YAW_HI, YAW_LO, 1'b1);
      push_target(YAW_HI, YAW_LO, 1'b1);
      push_target(YAW_HI, YAW_LO, 1'b1);
      push_target(YAW_LO, 0, 1'b0);
      push_target(21845, -21846, 1'b0);
      push_target(-21846, 21845, 1'b1);
      repeat (6) push_target(5000, 1000, 1'b0);
      repeat (3) push_target(5000, 1000, 1'b1);
      wait_drained();

      // largest gains, acceleration and time step: rates saturate, widest snap window in the bench
      program_settings(1023, 255, 1023, 255, 65535, 65535, 2560, 11520);
      queue_phase(100);
      wait_drained();

      // zero settings: frozen axes, snap disabled, pitch pinned to zero
      program_settings(0, 0, 0, 0, 0, 0, 0, 0);
      queue_phase(30);
      wait_drained();

      for (ph = 0; ph < 7; ph++) begin
         program_random_settings();
         queue_phase(232);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("PASS spring_damper_pan_tilt_tracker_core");
      end else begin
         $display("FAIL spring_damper_pan_tilt_tracker_core");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/sdpt_pkg.sv
rtl/core/sdpt_mul.sv
rtl/core/spring_damper_pan_tilt_tracker_core.sv
tb/sv/tb_top.sv
